@@ hw/rtl/pnew_pkg.sv @@
package pnew_pkg;

	localparam int MAX_WIDTH = 2048;
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int PIX_W = 24;
	localparam int WEIGHT_W = 17;
	localparam int IMG_WIDTH_W = 12;
	localparam int SCALE_W = 24;
	localparam int CFG_DATA_W = 24;

	localparam logic [IMG_WIDTH_W-1:0] IMG_WIDTH_RESET = 12'd640;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd32768;
	localparam logic [IMG_WIDTH_W-1:0] IMG_WIDTH_MIN = 12'd2;
	localparam logic [IMG_WIDTH_W-1:0] IMG_WIDTH_MAX = IMG_WIDTH_W'(MAX_WIDTH);

	// Exponent at or above 12.0 in Q.24 gives a zero weight.
	localparam logic [40:0] EXP_CUTOFF = 41'd12 << 24;
	localparam logic [32:0] ONE_Q31 = 33'h1_0000_0000 >> 1;
	localparam logic [3:0] SERIES_LAST = 4'd15;

	typedef enum logic [0:0] {
		CFG_IMAGE_WIDTH = 1'b0,
		CFG_DECAY_SCALE = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       frame_start;
	} pix_item_t;

	typedef struct packed {
		logic [WEIGHT_W-1:0] weight_left;
		logic                left_valid;
		logic [WEIGHT_W-1:0] weight_above;
		logic                above_valid;
	} link_item_t;

	typedef enum logic [1:0] {
		T_IDLE,
		T_READ,
		T_CALC
	} top_state_t;

	typedef enum logic [3:0] {
		W_IDLE,
		W_SQRT,
		W_MUL,
		W_CHECK,
		W_TERM_A,
		W_TERM_B,
		W_TERM_C,
		W_SQUARE,
		W_FIN,
		W_DONE
	} wu_state_t;

	// floor(2^32 / k) for the series divisors.
	function automatic logic [32:0] recip(input logic [3:0] k);
		logic [32:0] r;
		unique case (k)
			4'd1:  r = 33'd4294967296;
			4'd2:  r = 33'd2147483648;
			4'd3:  r = 33'd1431655765;
			4'd4:  r = 33'd1073741824;
			4'd5:  r = 33'd858993459;
			4'd6:  r = 33'd715827882;
			4'd7:  r = 33'd613566756;
			4'd8:  r = 33'd536870912;
			4'd9:  r = 33'd477218588;
			4'd10: r = 33'd429496729;
			4'd11: r = 33'd390451572;
			4'd12: r = 33'd357913941;
			4'd13: r = 33'd330382099;
			4'd14: r = 33'd306783378;
			4'd15: r = 33'd286331153;
			default: r = 33'd4294967296;
		endcase
		return r;
	endfunction

endpackage

@@ hw/rtl/pnew_ram.sv @@
module pnew_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

@@ hw/rtl/pnew_weight.sv @@
module pnew_weight (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [pnew_pkg::PIX_W-1:0]     pix_a,
	input  logic [pnew_pkg::PIX_W-1:0]     pix_b,
	input  logic [pnew_pkg::SCALE_W-1:0]   scale,
	output logic                           done,
	output logic [pnew_pkg::WEIGHT_W-1:0]  weight
);

	pnew_pkg::wu_state_t state_q, state_d;

	logic [34:0] rem_q, root_q;
	logic [4:0]  it_q;
	logic [40:0] t_q;
	logic [30:0] u_q, p_q, q0_q;
	logic [31:0] term_q;
	logic [32:0] acc_q;
	logic [3:0]  k_q;
	logic [1:0]  sqn_q;
	logic [pnew_pkg::WEIGHT_W-1:0] weight_q;

	logic signed [8:0]  dr, dg, db;
	logic signed [17:0] pr, pg, pb;
	logic [17:0] sum_sq;
	logic [34:0] sq_bit, sq_trial;
	logic [62:0] term_prod;
	logic [63:0] recip_prod;
	logic [34:0] qk;
	logic [34:0] rem_div;
	logic [30:0] q_fix;
	logic [32:0] acc_new;
	logic [63:0] square;
	logic [32:0] rounded;

	assign dr = $signed({1'b0, pix_a[23:16]}) - $signed({1'b0, pix_b[23:16]});
	assign dg = $signed({1'b0, pix_a[15:8]}) - $signed({1'b0, pix_b[15:8]});
	assign db = $signed({1'b0, pix_a[7:0]}) - $signed({1'b0, pix_b[7:0]});
	assign pr = dr * dr;
	assign pg = dg * dg;
	assign pb = db * db;
	assign sum_sq = 18'(pr[15:0]) + 18'(pg[15:0]) + 18'(pb[15:0]);

	// One root bit per cycle, classic remainder form.
	assign sq_bit = 35'(1) << {it_q, 1'b0};
	assign sq_trial = root_q + sq_bit;

	assign term_prod = 63'(term_q) * 63'(u_q);
	assign recip_prod = 64'(p_q) * 64'(pnew_pkg::recip(k_q));

	// The reciprocal estimate is low by at most one.
	assign qk = 35'(q0_q) * 35'(k_q);
	assign rem_div = 35'(p_q) - qk;
	assign q_fix = q0_q + 31'(rem_div >= 35'(k_q));

	always_comb begin
		if (k_q[0]) begin
			acc_new = (acc_q >= 33'(q_fix)) ? acc_q - 33'(q_fix) : '0;
		end else begin
			acc_new = acc_q + 33'(q_fix);
		end
	end

	assign square = 64'(acc_q[31:0]) * 64'(acc_q[31:0]) + (64'd1 << 30);
	assign rounded = acc_q + 33'h4000;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pnew_pkg::W_IDLE, pnew_pkg::W_DONE: begin
				if (start) state_d = pnew_pkg::W_SQRT;
			end
			pnew_pkg::W_SQRT: begin
				if (it_q == '0) state_d = pnew_pkg::W_MUL;
			end
			pnew_pkg::W_MUL: state_d = pnew_pkg::W_CHECK;
			pnew_pkg::W_CHECK: begin
				state_d = (t_q >= pnew_pkg::EXP_CUTOFF) ? pnew_pkg::W_DONE : pnew_pkg::W_TERM_A;
			end
			pnew_pkg::W_TERM_A: state_d = pnew_pkg::W_TERM_B;
			pnew_pkg::W_TERM_B: state_d = pnew_pkg::W_TERM_C;
			pnew_pkg::W_TERM_C: begin
				state_d = (k_q == pnew_pkg::SERIES_LAST) ? pnew_pkg::W_SQUARE : pnew_pkg::W_TERM_A;
			end
			pnew_pkg::W_SQUARE: begin
				if (sqn_q == 2'd3) state_d = pnew_pkg::W_FIN;
			end
			pnew_pkg::W_FIN: state_d = pnew_pkg::W_DONE;
			default: state_d = pnew_pkg::W_IDLE;
		endcase
	end

	always_comb begin
		done = (state_q == pnew_pkg::W_DONE);
		weight = weight_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pnew_pkg::W_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			pnew_pkg::W_IDLE, pnew_pkg::W_DONE: begin
				if (start) begin
					rem_q <= 35'({sum_sq, 16'b0});
					root_q <= '0;
					it_q <= 5'd16;
				end
			end
			pnew_pkg::W_SQRT: begin
				if (rem_q >= sq_trial) begin
					rem_q <= rem_q - sq_trial;
					root_q <= (root_q >> 1) + sq_bit;
				end else begin
					root_q <= root_q >> 1;
				end
				it_q <= it_q - 5'd1;
			end
			pnew_pkg::W_MUL: t_q <= 41'(root_q[16:0]) * 41'(scale);
			pnew_pkg::W_CHECK: begin
				weight_q <= '0;
				u_q <= {t_q[27:0], 3'b0};
				term_q <= pnew_pkg::ONE_Q31[31:0];
				acc_q <= pnew_pkg::ONE_Q31;
				k_q <= 4'd1;
			end
			pnew_pkg::W_TERM_A: p_q <= term_prod[61:31];
			pnew_pkg::W_TERM_B: q0_q <= recip_prod[62:32];
			pnew_pkg::W_TERM_C: begin
				term_q <= 32'(q_fix);
				k_q <= k_q + 4'd1;
				sqn_q <= '0;
				if (k_q == pnew_pkg::SERIES_LAST && acc_new > pnew_pkg::ONE_Q31) begin
					acc_q <= pnew_pkg::ONE_Q31;
				end else begin
					acc_q <= acc_new;
				end
			end
			pnew_pkg::W_SQUARE: begin
				acc_q <= square[63:31];
				sqn_q <= sqn_q + 2'd1;
			end
			pnew_pkg::W_FIN: weight_q <= rounded[31:15];
			default: ;
		endcase
	end

endmodule

@@ hw/rtl/pixel_neighbor_edge_weights.sv @@
// Each accepted item's result is set by the weight units: 17 root steps, a 15-term
// series of three steps a term and 4 squarings; a unit whose exponent reaches the cutoff
// skips the series and the squarings.
// Only one item is taken at a time; a new item is held off until the result is loaded
// into the output register. Two weight units run side by side.
// Reset clears position, previous pixel, configuration and output valid; the row memory is not cleared.
module pixel_neighbor_edge_weights (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  pnew_pkg::pix_item_t               in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output pnew_pkg::link_item_t              out_data,
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [pnew_pkg::CFG_DATA_W-1:0]   cfg_data
);

	pnew_pkg::top_state_t state_q, state_d;

	logic [pnew_pkg::IMG_WIDTH_W-1:0] image_width_q;
	logic [pnew_pkg::SCALE_W-1:0]     decay_scale_q;
	logic [pnew_pkg::PIX_W-1:0]       prev_q, pix_q;
	logic [pnew_pkg::COL_W-1:0]       col_q, cur_col_q;
	logic                             first_row_q, left_ok_q, above_ok_q;
	logic                             out_valid_q;
	pnew_pkg::link_item_t             out_data_q;

	logic accept, start, both_done, out_free, load_out;
	logic [pnew_pkg::COL_W-1:0]       col;
	logic                             first_row;
	logic [pnew_pkg::IMG_WIDTH_W-1:0] width;
	logic [pnew_pkg::PIX_W-1:0]       row_rd, pix_in, above_pix;
	logic left_done, above_done;
	logic [pnew_pkg::WEIGHT_W-1:0]    w_left, w_above;

	assign pix_in = {in_data.blue, in_data.green, in_data.red};
	assign accept = in_valid && !in_stall;
	assign col = in_data.frame_start ? '0 : col_q;
	assign first_row = in_data.frame_start ? 1'b1 : first_row_q;

	always_comb begin
		if (image_width_q < pnew_pkg::IMG_WIDTH_MIN) begin
			width = pnew_pkg::IMG_WIDTH_MIN;
		end else if (image_width_q > pnew_pkg::IMG_WIDTH_MAX) begin
			width = pnew_pkg::IMG_WIDTH_MAX;
		end else begin
			width = image_width_q;
		end
	end

	// The row entry is read when the item is taken and written back in the next cycle;
	// the next item is taken only after the result, so the two never overlap.
	pnew_ram #(
		.WIDTH(pnew_pkg::PIX_W),
		.DEPTH(pnew_pkg::MAX_WIDTH)
	) u_row (
		.clk(clk),
		.we(state_q == pnew_pkg::T_READ),
		.wr_addr(cur_col_q),
		.wr_data(pix_q),
		.rd_addr(col),
		.rd_data(row_rd)
	);

	assign start = (state_q == pnew_pkg::T_READ);

	// In the first row the row entry may never have been written; the upper weight is
	// masked then, so the unit is fed the pixel itself.
	assign above_pix = above_ok_q ? row_rd : pix_q;

	pnew_weight u_left (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.pix_a(pix_q),
		.pix_b(prev_q),
		.scale(decay_scale_q),
		.done(left_done),
		.weight(w_left)
	);

	pnew_weight u_above (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.pix_a(pix_q),
		.pix_b(above_pix),
		.scale(decay_scale_q),
		.done(above_done),
		.weight(w_above)
	);

	assign both_done = left_done && above_done;
	assign out_free = !out_valid_q || !out_stall;
	assign load_out = (state_q == pnew_pkg::T_CALC) && both_done && out_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pnew_pkg::T_IDLE: if (accept) state_d = pnew_pkg::T_READ;
			pnew_pkg::T_READ: state_d = pnew_pkg::T_CALC;
			pnew_pkg::T_CALC: if (both_done && out_free) state_d = pnew_pkg::T_IDLE;
			default: state_d = pnew_pkg::T_IDLE;
		endcase
	end

	always_comb begin
		in_stall = (state_q != pnew_pkg::T_IDLE);
		out_valid = out_valid_q;
		out_data = out_data_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pnew_pkg::T_IDLE;
			image_width_q <= pnew_pkg::IMG_WIDTH_RESET;
			decay_scale_q <= pnew_pkg::SCALE_RESET;
			prev_q <= '0;
			col_q <= '0;
			first_row_q <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (pnew_pkg::cfg_idx_t'(cfg_index))
					pnew_pkg::CFG_IMAGE_WIDTH: image_width_q <= cfg_data[pnew_pkg::IMG_WIDTH_W-1:0];
					pnew_pkg::CFG_DECAY_SCALE: decay_scale_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				if (pnew_pkg::IMG_WIDTH_W'(col) + 1'b1 >= width) begin
					col_q <= '0;
					first_row_q <= 1'b0;
				end else begin
					col_q <= col + 1'b1;
					first_row_q <= first_row;
				end
			end
			if (start) begin
				prev_q <= pix_q;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_q <= pix_in;
			cur_col_q <= col;
			left_ok_q <= (col != '0);
			above_ok_q <= !first_row;
		end
		if (load_out) begin
			out_data_q.weight_left <= left_ok_q ? w_left : '0;
			out_data_q.left_valid <= left_ok_q;
			out_data_q.weight_above <= above_ok_q ? w_above : '0;
			out_data_q.above_valid <= above_ok_q;
		end
	end

endmodule

@@ hw/rtl/pnew_checker.sv @@
module pnew_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_stall,
	input pnew_pkg::pix_item_t             in_data,
	input logic                            out_valid,
	input logic                            out_stall,
	input pnew_pkg::link_item_t            out_data,
	input logic                            cfg_we,
	input logic                            cfg_index,
	input logic [pnew_pkg::CFG_DATA_W-1:0] cfg_data
);

	// Only one item is in flight, so the input is held off right after a take.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("item taken while another was in flight");

	a_left_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.left_valid |-> out_data.weight_left == '0)
		else $error("left weight set without a left neighbor");

	a_above_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.above_valid |-> out_data.weight_above == '0)
		else $error("upper weight set without an upper neighbor");

	a_weight_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.weight_left <= 17'd65536 && out_data.weight_above <= 17'd65536)
		else $error("weight above 1.0");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

endmodule

bind pixel_neighbor_edge_weights pnew_checker u_pnew_checker (.*);
